// File: rtl/core/ddq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddq_pkg;

    // Default geometry
    localparam int DDQ_DEPTH      = 16;
    localparam int DDQ_DATA_WIDTH = 32;

    // Fixed field widths of the stream items
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int MPOS_W   = 4;
    localparam int OCC_W    = 5;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_HEAD = 3'd0,
        REQ_PUSH_TAIL = 3'd1,
        REQ_POP_TAIL  = 3'd2,
        REQ_POP_HEAD  = 3'd3,
        REQ_SEARCH    = 3'd4
    } t_req;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic push_head;   // shift toward tail, cell 0 takes the new value
        logic push_tail;   // cell at index == count takes the new value
        logic pop_head;    // shift toward head
        logic lane_clr;    // clear the result lane
        logic lane_shift;  // advance the result lane one cell toward head
        logic is_tail;     // lane hunts for the tail entry instead of a match
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/core/ddq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ddq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int POS_W      = 4,
    parameter int IDX        = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ddq_pkg::t_cell_ctl    i_ctl,
    input  wire [CNT_W-1:0]       i_count,
    input  wire [DATA_WIDTH-1:0]  i_value,
    input  wire [DATA_WIDTH-1:0]  i_prev_data,
    input  wire [DATA_WIDTH-1:0]  i_next_data,
    input  wire                   i_next_hit,
    input  wire [DATA_WIDTH-1:0]  i_next_lane_data,
    input  wire [POS_W-1:0]       i_next_lane_pos,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_lane_hit,
    output logic [DATA_WIDTH-1:0] o_lane_data,
    output logic [POS_W-1:0]      o_lane_pos
);

    import ddq_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_C1 = CNT_W'(IDX + 1);
    localparam logic [POS_W-1:0] IDX_P  = POS_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_lane_hit;
    logic [DATA_WIDTH-1:0] r_lane_data;
    logic [POS_W-1:0]      r_lane_pos;
    logic                  w_hit;

    // This cell is the tail, or an occupied cell equal to the key
    always_comb begin
        if (i_ctl.is_tail) begin
            w_hit = (IDX_C1 == i_count);
        end else begin
            w_hit = (IDX_C < i_count) && (r_data == i_value);
        end
    end

    // Entry storage: shift with neighbors or load at the tail slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_head) begin
            r_data <= i_prev_data;
        end else if (i_ctl.pop_head) begin
            r_data <= i_next_data;
        end else if (i_ctl.push_tail && (IDX_C == i_count)) begin
            r_data <= i_value;
        end
    end

    // Result lane valid: own hit overrides whatever arrives from the tail side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_hit <= 1'b0;
        end else if (i_ctl.lane_clr) begin
            r_lane_hit <= 1'b0;
        end else if (i_ctl.lane_shift) begin
            r_lane_hit <= w_hit | i_next_hit;
        end
    end

    // Result lane payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.lane_shift) begin
            if (w_hit) begin
                r_lane_data <= r_data;
                r_lane_pos  <= IDX_P;
            end else begin
                r_lane_data <= i_next_lane_data;
                r_lane_pos  <= i_next_lane_pos;
            end
        end
    end

    assign o_data      = r_data;
    assign o_lane_hit  = r_lane_hit;
    assign o_lane_data = r_lane_data;
    assign o_lane_pos  = r_lane_pos;

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue_with_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata                                         tuser
// s_axis    in   [31:0] value_in                               [2:0] req_type
// m_axis    out  [31:0] value_out, [35:32] match_position,     [1:0] status, [2] found
//                [40:36] occupancy, [47:41] zero
//
// Push head, push tail, pop head, an empty pop tail and unused codes finish
// in the accept cycle. Pop tail on a non-empty queue and search walk the
// result lane along the cell chain one cell per cycle toward the head, then
// the finish state loads the output register.
// Reset is synchronous, active low, and empties the queue at once.
// A new item is taken while idle with the output register free or being
// drained in the same cycle; a stalled output holds its item.

module double_ended_queue_with_search #(
    parameter int DEPTH      = ddq_pkg::DDQ_DEPTH,
    parameter int DATA_WIDTH = ddq_pkg::DDQ_DATA_WIDTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] value_in
    input  wire  [2:0]  s_axis_tuser,   // [2:0] req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] value_out, [35:32] match_position,
                                        // [40:36] occupancy, [47:41] zero
    output logic [2:0]  m_axis_tuser    // [1:0] status, [2] found
);

    import ddq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COLLECT,
        S_FINISH
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_step;
    logic [DATA_WIDTH-1:0] r_key;
    logic                  r_is_tail;

    logic                  r_out_valid;
    t_status               r_status;
    logic                  r_found;
    logic [VALUE_W-1:0]    r_value;
    logic [MPOS_W-1:0]     r_mpos;
    logic [OCC_W-1:0]      r_occ;

    t_cell_ctl             w_ctl;
    t_req                  w_req;
    logic                  w_accept;
    logic                  w_load_out;
    logic                  w_start_collect;
    t_status               w_status;
    logic                  w_found;
    logic [DATA_WIDTH-1:0] w_vout;
    logic [POS_W-1:0]      w_pos;
    logic [DATA_WIDTH-1:0] w_value;

    logic [DATA_WIDTH+VALUE_W-1:0] w_in_pad;
    logic [DATA_WIDTH-1:0]         w_in_val;
    logic [DATA_WIDTH+VALUE_W-1:0] w_vout_pad;
    logic [POS_W+MPOS_W-1:0]       w_pos_pad;
    logic [CNT_W+OCC_W-1:0]        w_occ_pad;

    logic [DATA_WIDTH-1:0] w_data      [DEPTH];
    logic [DATA_WIDTH-1:0] w_prev      [DEPTH];
    logic [DATA_WIDTH-1:0] w_next      [DEPTH];
    logic                  w_lhit      [DEPTH];
    logic [DATA_WIDTH-1:0] w_ldata     [DEPTH];
    logic [POS_W-1:0]      w_lpos      [DEPTH];
    logic                  w_nhit      [DEPTH];
    logic [DATA_WIDTH-1:0] w_nldata    [DEPTH];
    logic [POS_W-1:0]      w_nlpos     [DEPTH];

    // Field width adjustments
    assign w_in_pad   = {{DATA_WIDTH{1'b0}}, s_axis_tdata};
    assign w_in_val   = w_in_pad[DATA_WIDTH-1:0];
    assign w_vout_pad = {{VALUE_W{1'b0}}, w_vout};
    assign w_pos_pad  = {{MPOS_W{1'b0}}, w_pos};
    assign w_occ_pad  = {{OCC_W{1'b0}}, n_count};

    assign w_req    = t_req'(s_axis_tuser);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_value  = (r_state == S_IDLE) ? w_in_val : r_key;

    // Request decode and result selection
    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        w_ctl           = '0;
        w_load_out      = 1'b0;
        w_start_collect = 1'b0;
        w_status        = ST_OK;
        w_found         = 1'b0;
        w_vout          = '0;
        w_pos           = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_load_out = 1'b1;
                    case (w_req)
                        REQ_PUSH_HEAD, REQ_PUSH_TAIL: begin
                            if (r_count == DEPTH_C) begin
                                w_status = ST_FULL;
                            end else begin
                                w_ctl.push_head = (w_req == REQ_PUSH_HEAD);
                                w_ctl.push_tail = (w_req == REQ_PUSH_TAIL);
                                n_count = r_count + 1'b1;
                            end
                        end
                        REQ_POP_HEAD: begin
                            if (r_count == '0) begin
                                w_status = ST_EMPTY;
                            end else begin
                                w_vout       = w_data[0];
                                w_ctl.pop_head = 1'b1;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        REQ_POP_TAIL: begin
                            if (r_count == '0) begin
                                w_status = ST_EMPTY;
                            end else begin
                                w_load_out      = 1'b0;
                                w_start_collect = 1'b1;
                                w_ctl.lane_clr  = 1'b1;
                                n_state         = S_COLLECT;
                            end
                        end
                        REQ_SEARCH: begin
                            w_load_out      = 1'b0;
                            w_start_collect = 1'b1;
                            w_ctl.lane_clr  = 1'b1;
                            n_state         = S_COLLECT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COLLECT: begin
                w_ctl.lane_shift = 1'b1;
                w_ctl.is_tail    = r_is_tail;
                if (r_step == LAST_C) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                w_load_out = 1'b1;
                n_state    = S_IDLE;
                if (r_is_tail) begin
                    w_vout  = w_ldata[0];
                    n_count = r_count - 1'b1;
                end else if (w_lhit[0]) begin
                    w_found = 1'b1;
                    w_vout  = w_ldata[0];
                    w_pos   = w_lpos[0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, occupancy and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_is_tail   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_start_collect) begin
                r_step    <= '0;
                r_is_tail <= (w_req == REQ_POP_TAIL);
                r_key     <= w_in_val;
            end else if (r_state == S_COLLECT) begin
                r_step <= r_step + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_status    <= w_status;
                r_found     <= w_found;
                r_value     <= w_vout_pad[VALUE_W-1:0];
                r_mpos      <= w_pos_pad[MPOS_W-1:0];
                r_occ       <= w_occ_pad[OCC_W-1:0];
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_occ, r_mpos, r_value};
    assign m_axis_tuser  = {r_found, r_status};

    // Cell chain: index 0 is the head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = w_value;
        end else begin : g_mid_prev
            assign w_prev[g] = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g]   = '0;
            assign w_nhit[g]   = 1'b0;
            assign w_nldata[g] = '0;
            assign w_nlpos[g]  = '0;
        end else begin : g_mid_next
            assign w_next[g]   = w_data[g+1];
            assign w_nhit[g]   = w_lhit[g+1];
            assign w_nldata[g] = w_ldata[g+1];
            assign w_nlpos[g]  = w_lpos[g+1];
        end

        ddq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .POS_W      (POS_W),
            .IDX        (g)
        ) u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctl            (w_ctl),
            .i_count          (r_count),
            .i_value          (w_value),
            .i_prev_data      (w_prev[g]),
            .i_next_data      (w_next[g]),
            .i_next_hit       (w_nhit[g]),
            .i_next_lane_data (w_nldata[g]),
            .i_next_lane_pos  (w_nlpos[g]),
            .o_data           (w_data[g]),
            .o_lane_hit       (w_lhit[g]),
            .o_lane_data      (w_ldata[g]),
            .o_lane_pos       (w_lpos[g])
        );
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("occupancy above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> (r_count == DEPTH_C))
        else $error("full status while not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_EMPTY)) |-> (r_count == '0))
        else $error("empty status while not empty");

    a_collect_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COLLECT) |-> !r_out_valid)
        else $error("output register busy during lane walk");

endmodule

`default_nettype wire
